/* design/oledtb_pkg.sv */
// ----------------------------------------------------------------------------
// oledtb_pkg
// Shared types, codes and constant tables for the OLED text byte generator.
// ----------------------------------------------------------------------------
package oledtb_pkg;

    localparam int INIT_LEN  = 23;
    localparam int CURS_LEN  = 3;
    localparam int CHAR_LEN  = 6;
    localparam int GLYPH_W   = 5;
    localparam int FIRST_CHAR = 32;

    typedef enum logic [1:0] {
        KIND_INIT   = 2'd0,
        KIND_CURSOR = 2'd1,
        KIND_CHAR   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SRC_INIT  = 2'd0,
        SRC_GLYPH = 2'd1,
        SRC_IMM   = 2'd2
    } src_t;

    // one ROM read request with the flags that travel alongside it
    typedef struct packed {
        src_t       src;
        logic [6:0] glyph_idx;
        logic [4:0] cnt;
        logic [7:0] imm;
        logic       is_cmd;
        logic       last;
    } rd_req_t;

    typedef struct packed {
        logic busy;
        logic issue;
        logic last;
    } seq_status_t;

    function automatic logic [7:0] init_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:  b = 8'hAE;
            5'd1:  b = 8'hD5;
            5'd2:  b = 8'h80;
            5'd3:  b = 8'hA8;
            5'd4:  b = 8'h3F;
            5'd5:  b = 8'hD3;
            5'd6:  b = 8'h00;
            5'd7:  b = 8'h40;
            5'd8:  b = 8'h8D;
            5'd9:  b = 8'h14;
            5'd10: b = 8'hA1;
            5'd11: b = 8'hC8;
            5'd12: b = 8'hDA;
            5'd13: b = 8'h12;
            5'd14: b = 8'h81;
            5'd15: b = 8'hCF;
            5'd16: b = 8'hD9;
            5'd17: b = 8'hF1;
            5'd18: b = 8'hDB;
            5'd19: b = 8'h40;
            5'd20: b = 8'hA4;
            5'd21: b = 8'hA6;
            5'd22: b = 8'hAF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // five columns of a glyph, leftmost column in the top byte, bit 0 at the top
    function automatic logic [39:0] glyph_row(input logic [6:0] idx);
        logic [39:0] r;
        case (idx)
            7'd0:  r = 40'h00_00_00_00_00;
            7'd1:  r = 40'h00_00_5F_00_00;
            7'd2:  r = 40'h00_07_00_07_00;
            7'd3:  r = 40'h14_7F_14_7F_14;
            7'd4:  r = 40'h24_2A_7F_2A_12;
            7'd5:  r = 40'h23_13_08_64_62;
            7'd6:  r = 40'h36_49_55_22_50;
            7'd7:  r = 40'h00_05_03_00_00;
            7'd8:  r = 40'h00_1C_22_41_00;
            7'd9:  r = 40'h00_41_22_1C_00;
            7'd10: r = 40'h14_08_3E_08_14;
            7'd11: r = 40'h08_08_3E_08_08;
            7'd12: r = 40'h00_50_30_00_00;
            7'd13: r = 40'h08_08_08_08_08;
            7'd14: r = 40'h00_60_60_00_00;
            7'd15: r = 40'h20_10_08_04_02;
            7'd16: r = 40'h3E_51_49_45_3E;
            7'd17: r = 40'h00_42_7F_40_00;
            7'd18: r = 40'h42_61_51_49_46;
            7'd19: r = 40'h21_41_45_4B_31;
            7'd20: r = 40'h18_14_12_7F_10;
            7'd21: r = 40'h27_45_45_45_39;
            7'd22: r = 40'h3C_4A_49_49_30;
            7'd23: r = 40'h01_71_09_05_03;
            7'd24: r = 40'h36_49_49_49_36;
            7'd25: r = 40'h06_49_49_29_1E;
            7'd26: r = 40'h00_36_36_00_00;
            7'd27: r = 40'h00_56_36_00_00;
            7'd28: r = 40'h08_14_22_41_00;
            7'd29: r = 40'h14_14_14_14_14;
            7'd30: r = 40'h00_41_22_14_08;
            7'd31: r = 40'h02_01_51_09_06;
            7'd32: r = 40'h32_49_79_41_3E;
            7'd33: r = 40'h7E_11_11_11_7E;
            7'd34: r = 40'h7F_49_49_49_36;
            7'd35: r = 40'h3E_41_41_41_22;
            7'd36: r = 40'h7F_41_41_41_3E;
            7'd37: r = 40'h7F_49_49_49_41;
            7'd38: r = 40'h7F_09_09_09_01;
            7'd39: r = 40'h3E_41_49_49_7A;
            7'd40: r = 40'h7F_08_08_08_7F;
            7'd41: r = 40'h00_41_7F_41_00;
            7'd42: r = 40'h20_40_41_3F_01;
            7'd43: r = 40'h7F_08_14_22_41;
            7'd44: r = 40'h7F_40_40_40_40;
            7'd45: r = 40'h7F_02_04_02_7F;
            7'd46: r = 40'h7F_04_08_10_7F;
            7'd47: r = 40'h3E_41_41_41_3E;
            7'd48: r = 40'h7F_09_09_09_06;
            7'd49: r = 40'h3E_41_51_21_5E;
            7'd50: r = 40'h7F_09_19_29_46;
            7'd51: r = 40'h46_49_49_49_31;
            7'd52: r = 40'h01_01_7F_01_01;
            7'd53: r = 40'h3F_40_40_40_3F;
            7'd54: r = 40'h1F_20_40_20_1F;
            7'd55: r = 40'h7F_20_18_20_7F;
            7'd56: r = 40'h63_14_08_14_63;
            7'd57: r = 40'h03_04_78_04_03;
            7'd58: r = 40'h61_51_49_45_43;
            7'd59: r = 40'h00_7F_41_41_00;
            7'd60: r = 40'h02_04_08_10_20;
            7'd61: r = 40'h00_41_41_7F_00;
            7'd62: r = 40'h04_02_01_02_04;
            7'd63: r = 40'h40_40_40_40_40;
            7'd64: r = 40'h00_03_05_00_00;
            7'd65: r = 40'h20_54_54_54_78;
            7'd66: r = 40'h7F_48_44_44_38;
            7'd67: r = 40'h38_44_44_44_20;
            7'd68: r = 40'h38_44_44_48_7F;
            7'd69: r = 40'h38_54_54_54_18;
            7'd70: r = 40'h08_7E_09_01_02;
            7'd71: r = 40'h08_14_54_54_3C;
            7'd72: r = 40'h7F_08_04_04_78;
            7'd73: r = 40'h00_44_7D_40_00;
            7'd74: r = 40'h20_40_40_44_3D;
            7'd75: r = 40'h7F_10_28_44_00;
            7'd76: r = 40'h00_41_7F_40_00;
            7'd77: r = 40'h7C_04_18_04_78;
            7'd78: r = 40'h7C_08_04_04_78;
            7'd79: r = 40'h38_44_44_44_38;
            7'd80: r = 40'h7C_14_14_14_08;
            7'd81: r = 40'h08_14_14_18_7C;
            7'd82: r = 40'h7C_08_04_04_08;
            7'd83: r = 40'h48_54_54_54_20;
            7'd84: r = 40'h04_3F_44_40_20;
            7'd85: r = 40'h3C_40_40_20_7C;
            7'd86: r = 40'h1C_20_40_20_1C;
            7'd87: r = 40'h3C_40_30_40_3C;
            7'd88: r = 40'h44_28_10_28_44;
            7'd89: r = 40'h0C_50_50_50_3C;
            7'd90: r = 40'h44_64_54_4C_44;
            7'd91: r = 40'h00_08_36_41_00;
            7'd92: r = 40'h00_00_7F_00_00;
            7'd93: r = 40'h00_41_36_08_00;
            7'd94: r = 40'h08_08_2A_1C_08;
            7'd95: r = 40'h08_1C_2A_08_08;
            default: r = 40'h00_00_00_00_00;
        endcase
        return r;
    endfunction

endpackage

/* design/oledtb_rom.sv */
// ----------------------------------------------------------------------------
// oledtb_rom
// Synchronous byte ROM holding the init sequence and the 5x7 font, one read
// per cycle with registered data; immediate bytes pass through the same port.
// ----------------------------------------------------------------------------
module oledtb_rom (
    input  logic              aclk,
    input  logic              rd_en,
    input  oledtb_pkg::rd_req_t rd_req,
    output logic [7:0]        rd_data
);

    logic [7:0]  data_reg;
    logic [39:0] row;
    logic [7:0]  glyph_byte;

    always_comb begin
        row = oledtb_pkg::glyph_row(rd_req.glyph_idx);
        case (rd_req.cnt[2:0])
            3'd0:    glyph_byte = row[39:32];
            3'd1:    glyph_byte = row[31:24];
            3'd2:    glyph_byte = row[23:16];
            3'd3:    glyph_byte = row[15:8];
            3'd4:    glyph_byte = row[7:0];
            default: glyph_byte = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            unique case (rd_req.src)
                oledtb_pkg::SRC_INIT:  data_reg <= oledtb_pkg::init_byte(rd_req.cnt);
                oledtb_pkg::SRC_GLYPH: data_reg <= glyph_byte;
                oledtb_pkg::SRC_IMM:   data_reg <= rd_req.imm;
                default:               data_reg <= 8'h00;
            endcase
        end
    end

    assign rd_data = data_reg;

endmodule

/* design/oledtb_seq.sv */
// ----------------------------------------------------------------------------
// oledtb_seq
// Request sequencer: holds the current request and issues one ROM read per
// cycle while the output stage can take a byte.
// ----------------------------------------------------------------------------
module oledtb_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_kind,
    input  logic [6:0]              s_column,
    input  logic [2:0]              s_page,
    input  logic [7:0]              s_char_code,
    input  logic                    advance,
    output oledtb_pkg::rd_req_t     rd_req,
    output oledtb_pkg::seq_status_t status
);

    logic              busy_reg, busy_next;
    oledtb_pkg::kind_t kind_reg, kind_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [6:0]        column_reg, column_next;
    logic [2:0]        page_reg, page_next;
    logic [6:0]        idx_reg, idx_next;

    logic       issue;
    logic       last;
    logic       accept;
    logic [4:0] last_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        kind_reg   <= kind_next;
        cnt_reg    <= cnt_next;
        column_reg <= column_next;
        page_reg   <= page_next;
        idx_reg    <= idx_next;
    end

    always_comb begin
        unique case (kind_reg)
            oledtb_pkg::KIND_INIT:   last_cnt = 5'(oledtb_pkg::INIT_LEN - 1);
            oledtb_pkg::KIND_CURSOR: last_cnt = 5'(oledtb_pkg::CURS_LEN - 1);
            oledtb_pkg::KIND_CHAR:   last_cnt = 5'(oledtb_pkg::CHAR_LEN - 1);
            default:                 last_cnt = 5'd0;
        endcase
        issue   = busy_reg && advance;
        last    = (cnt_reg == last_cnt);
        s_ready = !busy_reg || (issue && last);
        accept  = s_valid && s_ready;

        busy_next   = busy_reg;
        kind_next   = kind_reg;
        cnt_next    = cnt_reg;
        column_next = column_reg;
        page_next   = page_reg;
        idx_next    = idx_reg;

        if (issue) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 5'd1;
            end
        end
        if (accept) begin
            // unknown kind is taken and dropped
            busy_next   = (oledtb_pkg::kind_t'(s_kind) != oledtb_pkg::KIND_NONE);
            kind_next   = oledtb_pkg::kind_t'(s_kind);
            cnt_next    = 5'd0;
            column_next = s_column;
            page_next   = s_page;
            // codes outside 32..127 draw as space
            if (!s_char_code[7] && (s_char_code[6:5] != 2'b00)) begin
                idx_next = s_char_code[6:0] - 7'(oledtb_pkg::FIRST_CHAR);
            end else begin
                idx_next = 7'd0;
            end
        end
    end

    always_comb begin
        rd_req.src       = oledtb_pkg::SRC_IMM;
        rd_req.glyph_idx = idx_reg;
        rd_req.cnt       = cnt_reg;
        rd_req.imm       = 8'h00;
        rd_req.is_cmd    = 1'b1;
        rd_req.last      = last;
        unique case (kind_reg)
            oledtb_pkg::KIND_INIT: begin
                rd_req.src = oledtb_pkg::SRC_INIT;
            end
            oledtb_pkg::KIND_CURSOR: begin
                case (cnt_reg[1:0])
                    2'd0:    rd_req.imm = {5'b10110, page_reg};
                    2'd1:    rd_req.imm = {4'h0, column_reg[3:0]};
                    default: rd_req.imm = {4'h1, 1'b0, column_reg[6:4]};
                endcase
            end
            oledtb_pkg::KIND_CHAR: begin
                rd_req.is_cmd = 1'b0;
                // trailing blank column comes from the immediate path
                if (cnt_reg < 5'(oledtb_pkg::GLYPH_W)) begin
                    rd_req.src = oledtb_pkg::SRC_GLYPH;
                end
            end
            default: begin
                rd_req.src = oledtb_pkg::SRC_IMM;
            end
        endcase
    end

    assign status.busy  = busy_reg;
    assign status.issue = issue;
    assign status.last  = last;

endmodule

/* design/oled_text_byte_generator_unit.sv */
// ----------------------------------------------------------------------------
// oled_text_byte_generator_unit
// Byte stream generator for a page-addressed 128x64 monochrome OLED.
// ----------------------------------------------------------------------------
// Each request produces bytes on the m_ channel at one byte per cycle while the
// output is not stalled by m_ready: a char request gives 6 bytes, a cursor
// request 3 and an init request 23. The request is first registered in the
// sequencer, which then reads the font/init ROM; the ROM data and m_valid are
// registered. The next request is taken in the same cycle as the final byte of
// the current one is read, so back-to-back requests stream without gaps. A
// request of unknown kind is taken and produces nothing.
module oled_text_byte_generator_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [6:0] s_column,
    input  logic [2:0] s_page,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_command,
    output logic       m_last
);

    oledtb_pkg::rd_req_t     rd_req;
    oledtb_pkg::seq_status_t status;

    logic m_valid_reg, m_valid_next;
    logic is_cmd_reg;
    logic last_reg;
    logic advance;

    // output stage can take a new byte
    assign advance = !m_valid_reg || m_ready;

    oledtb_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_column    (s_column),
        .s_page      (s_page),
        .s_char_code (s_char_code),
        .advance     (advance),
        .rd_req      (rd_req),
        .status      (status)
    );

    oledtb_rom u_rom (
        .aclk    (aclk),
        .rd_en   (status.issue),
        .rd_req  (rd_req),
        .rd_data (m_out_byte)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = status.issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (status.issue) begin
            is_cmd_reg <= rd_req.is_cmd;
            last_reg   <= rd_req.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_command = is_cmd_reg;
    assign m_last       = last_reg;

    a_issue_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        status.issue |=> m_valid_reg)
        else $error("issued byte did not reach output stage");

    a_ready_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy && s_ready |-> status.issue && status.last)
        else $error("request taken while current one still has bytes left");

    a_known_kind_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind != oledtb_pkg::KIND_NONE) |=> status.busy)
        else $error("accepted request did not start the sequencer");

    a_no_issue_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !status.issue)
        else $error("ROM read issued while output byte is stalled");

endmodule
